// ----- design/rssort_pkg.sv -----
`timescale 1ns / 1ps
package rssort_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  typedef struct packed {
    logic [63:0]        key_hi;
    logic [63:0]        key_mid;
    logic [23:0]        key_lo;
    logic [63:0]        maker_hi;
    logic [63:0]        maker_mid;
    logic [23:0]        maker_lo;
    logic signed [31:0] package_count;
    logic signed [31:0] price;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic logic key_below(input rec_t a, input rec_t b);
    return {a.key_hi, a.key_mid, a.key_lo} < {b.key_hi, b.key_mid, b.key_lo};
  endfunction

endpackage

// ----- design/rssort_in_if.sv -----
`timescale 1ns / 1ps
interface rssort_in_if;
  logic               valid;
  logic               ready;
  logic [63:0]        key_hi;
  logic [63:0]        key_mid;
  logic [23:0]        key_lo;
  logic [63:0]        maker_hi;
  logic [63:0]        maker_mid;
  logic [23:0]        maker_lo;
  logic signed [31:0] package_count;
  logic signed [31:0] price;
  logic               last_record;

  modport source (
    output valid, key_hi, key_mid, key_lo, maker_hi, maker_mid, maker_lo,
           package_count, price, last_record,
    input  ready
  );
  modport sink (
    input  valid, key_hi, key_mid, key_lo, maker_hi, maker_mid, maker_lo,
           package_count, price, last_record,
    output ready
  );
endinterface

// ----- design/rssort_out_if.sv -----
`timescale 1ns / 1ps
interface rssort_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        out_key_hi;
  logic [63:0]        out_key_mid;
  logic [23:0]        out_key_lo;
  logic [63:0]        out_maker_hi;
  logic [63:0]        out_maker_mid;
  logic [23:0]        out_maker_lo;
  logic signed [31:0] out_package_count;
  logic signed [31:0] out_price;
  logic               out_last;

  modport source (
    output valid, out_key_hi, out_key_mid, out_key_lo, out_maker_hi, out_maker_mid,
           out_maker_lo, out_package_count, out_price, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_key_hi, out_key_mid, out_key_lo, out_maker_hi, out_maker_mid,
           out_maker_lo, out_package_count, out_price, out_last,
    output ready
  );
endinterface

// ----- design/rssort_ram.sv -----
`timescale 1ns / 1ps
module rssort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/record_selection_sort_by_name_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Contents
// rec_in    in   one record per transfer; last_record closes the set and starts the sort
// rec_out   out  records in ascending key order; out_last on the final one
//
// Load: records are stored as accepted; records past the table capacity are dropped.
// Sort: selection sort on the key; one compare per cycle over the single read port
//   of the record RAM, swaps take two writes.
// Emit: per record a RAM read, then the output register, plus output stalls.
// rst (synchronous) empties the table and clears the output valid flag.
// rec_in is taken again while the final sorted record still waits in rec_out.
module record_selection_sort_by_name_unit (
  input  logic         clk,
  input  logic         rst,
  rssort_in_if.sink    rec_in,
  rssort_out_if.source rec_out
);
  import rssort_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_RD_I, S_CAP_I, S_SCAN, S_SWAP_A, S_SWAP_B, S_OUT_RD, S_OUT_WAIT
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] i_idx;
  logic [ADDR_W-1:0] jq;
  logic [ADDR_W-1:0] best_idx;
  logic [ADDR_W-1:0] k_idx;
  rec_t              best_rec;
  rec_t              rec_i;
  rec_t              out_rec;
  logic              out_valid;
  logic              out_last;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  rec_t              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  rec_t              ram_rdata;

  rec_t              in_rec;
  logic              accept_in;
  logic              has_room;
  logic [CNT_W-1:0]  cnt_after;
  logic [ADDR_W-1:0] last_idx;
  logic              rd_less;
  logic              i_more;
  state_t            pass_next;
  logic              out_free;

  assign in_rec = '{
    key_hi:        rec_in.key_hi,
    key_mid:       rec_in.key_mid,
    key_lo:        rec_in.key_lo,
    maker_hi:      rec_in.maker_hi,
    maker_mid:     rec_in.maker_mid,
    maker_lo:      rec_in.maker_lo,
    package_count: rec_in.package_count,
    price:         rec_in.price
  };

  assign rec_in.ready = (state == S_LOAD);
  assign accept_in    = rec_in.valid && rec_in.ready;
  assign has_room     = cnt < CNT_W'(MAX_RECORDS);
  assign cnt_after    = cnt + CNT_W'(has_room);
  assign last_idx     = ADDR_W'(cnt - CNT_W'(1));
  assign rd_less      = key_below(ram_rdata, best_rec);
  assign i_more       = (CNT_W'(i_idx) + CNT_W'(2)) < cnt;
  assign pass_next    = i_more ? S_RD_I : S_OUT_RD;
  assign out_free     = !out_valid || rec_out.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[ADDR_W-1:0];
    ram_wdata = in_rec;
    ram_raddr = k_idx;
    case (state)
      S_LOAD:   ram_we = accept_in && has_room;
      S_RD_I:   ram_raddr = i_idx;
      S_CAP_I:  ram_raddr = i_idx + ADDR_W'(1);
      S_SCAN:   ram_raddr = jq + ADDR_W'(1);
      S_SWAP_A: begin
        ram_we    = (best_idx != i_idx);
        ram_waddr = i_idx;
        ram_wdata = best_rec;
      end
      S_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx;
        ram_wdata = rec_i;
      end
      default:  ram_raddr = k_idx;
    endcase
  end

  rssort_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rec_out.ready && !(state == S_OUT_WAIT && out_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept_in) begin
            cnt <= cnt_after;
            if (rec_in.last_record) begin
              i_idx <= '0;
              k_idx <= '0;
              state <= (cnt_after == CNT_W'(1)) ? S_OUT_RD : S_RD_I;
            end
          end
        end
        S_RD_I: state <= S_CAP_I;
        S_CAP_I: begin
          rec_i    <= ram_rdata;
          best_rec <= ram_rdata;
          best_idx <= i_idx;
          jq       <= i_idx + ADDR_W'(1);
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_less) begin
            best_rec <= ram_rdata;
            best_idx <= jq;
          end
          if (jq == last_idx) begin
            state <= S_SWAP_A;
          end else begin
            jq <= jq + ADDR_W'(1);
          end
        end
        S_SWAP_A: begin
          if (best_idx == i_idx) begin
            i_idx <= i_idx + ADDR_W'(1);
            state <= pass_next;
          end else begin
            state <= S_SWAP_B;
          end
        end
        S_SWAP_B: begin
          i_idx <= i_idx + ADDR_W'(1);
          state <= pass_next;
        end
        S_OUT_RD: state <= S_OUT_WAIT;
        S_OUT_WAIT: begin
          if (out_free) begin
            out_rec   <= ram_rdata;
            out_last  <= (k_idx == last_idx);
            out_valid <= 1'b1;
            if (k_idx == last_idx) begin
              cnt   <= '0;
              state <= S_LOAD;
            end else begin
              k_idx <= k_idx + ADDR_W'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign rec_out.valid             = out_valid;
  assign rec_out.out_key_hi        = out_rec.key_hi;
  assign rec_out.out_key_mid       = out_rec.key_mid;
  assign rec_out.out_key_lo        = out_rec.key_lo;
  assign rec_out.out_maker_hi      = out_rec.maker_hi;
  assign rec_out.out_maker_mid     = out_rec.maker_mid;
  assign rec_out.out_maker_lo      = out_rec.maker_lo;
  assign rec_out.out_package_count = out_rec.package_count;
  assign rec_out.out_price         = out_rec.price;
  assign rec_out.out_last          = out_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_RECORDS))
    else $error("record count above capacity");

  a_best_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP_A) |-> (best_idx >= i_idx && best_idx <= last_idx))
    else $error("selected minimum outside the unsorted range");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_LOAD || state == S_SWAP_A || state == S_SWAP_B))
    else $error("record RAM written outside load or swap");

  a_final_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_WAIT && out_free && k_idx == last_idx)
      |=> (state == S_LOAD && cnt == '0 && out_valid && out_last))
    else $error("final record did not close the set");

endmodule

// ----- dv/record_sort_checker.sv -----
`timescale 1ns / 1ps
module record_sort_checker (
  input  logic  clk,
  input  logic  rst,
  rssort_in_if  rec_in,
  rssort_out_if rec_out,
  output int    errors,
  output int    pending
);
  import rssort_pkg::*;

  typedef struct {
    rec_t rec;
    logic last;
  } sorted_rec_t;

  rec_t        held_recs [MAX_RECORDS];
  int          held;
  sorted_rec_t sorted_q [$];

  always @(posedge clk) begin
    rec_t        got;
    rec_t        tmp;
    sorted_rec_t want;
    int          best;
    if (rst) begin
      held = 0;
      errors = 0;
      sorted_q.delete();
    end else begin
      if (rec_out.valid && rec_out.ready) begin
        got = {rec_out.out_key_hi, rec_out.out_key_mid, rec_out.out_key_lo,
               rec_out.out_maker_hi, rec_out.out_maker_mid, rec_out.out_maker_lo,
               rec_out.out_package_count, rec_out.out_price};
        if (sorted_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected record: key %h last %b",
                     {got.key_hi, got.key_mid, got.key_lo}, rec_out.out_last);
        end else begin
          want = sorted_q.pop_front();
          if (got !== want.rec || rec_out.out_last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("record mismatch at %0t", $realtime);
              $display("  expected key %h maker %h count %0d price %0d last %b",
                       {want.rec.key_hi, want.rec.key_mid, want.rec.key_lo},
                       {want.rec.maker_hi, want.rec.maker_mid, want.rec.maker_lo},
                       want.rec.package_count, want.rec.price, want.last);
              $display("  actual   key %h maker %h count %0d price %0d last %b",
                       {got.key_hi, got.key_mid, got.key_lo},
                       {got.maker_hi, got.maker_mid, got.maker_lo},
                       got.package_count, got.price, rec_out.out_last);
            end
          end
        end
      end
      if (rec_in.valid && rec_in.ready) begin
        if (held < MAX_RECORDS) begin
          held_recs[held] = {rec_in.key_hi, rec_in.key_mid, rec_in.key_lo,
                             rec_in.maker_hi, rec_in.maker_mid, rec_in.maker_lo,
                             rec_in.package_count, rec_in.price};
          held++;
        end
        if (rec_in.last_record) begin
          for (int i = 0; i + 1 < held; i++) begin
            best = i;
            for (int j = i + 1; j < held; j++)
              if ({held_recs[j].key_hi, held_recs[j].key_mid, held_recs[j].key_lo} <
                  {held_recs[best].key_hi, held_recs[best].key_mid,
                   held_recs[best].key_lo})
                best = j;
            if (best != i) begin
              tmp = held_recs[i];
              held_recs[i] = held_recs[best];
              held_recs[best] = tmp;
            end
          end
          for (int k = 0; k < held; k++) begin
            want.rec = held_recs[k];
            want.last = (k + 1 == held);
            sorted_q.push_back(want);
          end
          held = 0;
        end
      end
    end
    pending = sorted_q.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import rssort_pkg::*;

  localparam int TOTAL_RECORDS = 360;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   sent = 0;
  int   cycle_count = 0;
  int   errors;
  int   pending;

  rssort_in_if  in_ch ();
  rssort_out_if out_ch ();

  record_selection_sort_by_name_unit dut (
    .clk    (clk),
    .rst    (rst),
    .rec_in (in_ch.sink),
    .rec_out(out_ch.source)
  );

  record_sort_checker sort_chk (
    .clk    (clk),
    .rst    (rst),
    .rec_in (in_ch),
    .rec_out(out_ch),
    .errors (errors),
    .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** record_selection_sort_by_name_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic rec_t make_rec(input logic [151:0] k, input logic [151:0] m,
                                    input logic [31:0] cnt, input logic [31:0] cost);
    rec_t r;
    {r.key_hi, r.key_mid, r.key_lo} = k;
    {r.maker_hi, r.maker_mid, r.maker_lo} = m;
    r.package_count = cnt;
    r.price = cost;
    return r;
  endfunction

  function automatic rec_t random_rec();
    logic [151:0] k;
    logic [151:0] m;
    int           sel;
    int           len;
    sel = $urandom_range(9);
    m = {$urandom, $urandom, $urandom, $urandom, 24'($urandom)};
    if (sel < 3) begin
      k = {$urandom, $urandom, $urandom, $urandom, 24'($urandom)};
    end else if (sel < 6) begin
      case ($urandom_range(3))
        0: k = '0;
        1: k = '1;
        2: k = {8'h6d, 144'h0};
        default: k = {64'h0123456789abcdef, 88'h0};
      endcase
      k[1:0] = 2'($urandom_range(3));
    end else begin
      // zero-padded name; sometimes a stray byte after the terminator
      k = '0;
      len = $urandom_range(19);
      for (int i = 0; i < len; i++)
        k[151 - 8 * i -: 8] = 8'($urandom_range(97, 122));
      if (sel == 9 && len < 18)
        k[151 - 8 * (len + 1) -: 8] = 8'($urandom_range(97, 122));
    end
    return make_rec(k, m, $urandom, $urandom);
  endfunction

  task automatic send_rec(input rec_t r, input logic last);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.key_hi        <= r.key_hi;
    in_ch.key_mid       <= r.key_mid;
    in_ch.key_lo        <= r.key_lo;
    in_ch.maker_hi      <= r.maker_hi;
    in_ch.maker_mid     <= r.maker_mid;
    in_ch.maker_lo      <= r.maker_lo;
    in_ch.package_count <= r.package_count;
    in_ch.price         <= r.price;
    in_ch.last_record   <= last;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sent++;
    if (sent == 120) begin
      tx_idle_pct = 63;
      rx_idle_pct = 15;
    end else if (sent == 240) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int sz;
    int pick;
    in_ch.valid = 1'b0;
    in_ch.key_hi = '0;
    in_ch.key_mid = '0;
    in_ch.key_lo = '0;
    in_ch.maker_hi = '0;
    in_ch.maker_mid = '0;
    in_ch.maker_lo = '0;
    in_ch.package_count = '0;
    in_ch.price = '0;
    in_ch.last_record = 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 63;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_rec(make_rec('0, '0, 32'h7fffffff, 32'h80000000), 1'b1);
    send_rec(make_rec('1, '1, 32'h80000000, 32'h7fffffff), 1'b1);

    // equal keys: selection sort reorders them
    send_rec(make_rec(152'h5, 152'ha, 32'd1, 32'd10), 1'b0);
    send_rec(make_rec(152'h5, 152'hb, 32'd2, 32'd20), 1'b0);
    send_rec(make_rec(152'h1, 152'hc, 32'd3, 32'd30), 1'b1);

    // bytes past the terminator, keys that differ only in the lower words
    send_rec(make_rec({16'h6162, 8'h00, 8'h63, 120'h0}, 152'h1, 32'd4, -32'sd4), 1'b0);
    send_rec(make_rec({16'h6162, 136'h0}, 152'h2, 32'd5, -32'sd5), 1'b0);
    send_rec(make_rec({64'h0, 64'h0, 24'h000001}, 152'h3, 32'd6, -32'sd6), 1'b0);
    send_rec(make_rec({64'h0, 64'h1, 24'h0}, 152'h4, 32'd7, -32'sd7), 1'b1);

    // full table in descending order; the closing record is dropped
    for (int i = 0; i <= MAX_RECORDS; i++)
      send_rec(make_rec({8'(8'h61 + MAX_RECORDS - i), 144'h0}, 152'(i), i, -i),
               i == MAX_RECORDS);

    drain_results();

    while (sent < TOTAL_RECORDS) begin
      pick = $urandom_range(99);
      if (pick < 60)      sz = $urandom_range(1, 4);
      else if (pick < 80) sz = $urandom_range(5, 10);
      else if (pick < 90) sz = MAX_RECORDS;
      else if (pick < 95) sz = $urandom_range(11, MAX_RECORDS - 1);
      else                sz = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
      for (int i = 0; i < sz; i++)
        send_rec(random_rec(), i == sz - 1);
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** record_selection_sort_by_name_unit: PASSED **");
    end else begin
      $display("** record_selection_sort_by_name_unit: FAILED **");
    end
    $finish;
  end

endmodule
